// ===== rtl/ffd_pkg.sv =====
// Shared types and constants for the frame FIFO with drop-on-full.
package ffd_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int STAT_W = 3;
  localparam int DROP_W = 16;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_STORED   = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_POPPED   = 3'd4
  } ffd_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN_RD,
    S_STREAM
  } ffd_state_t;

  // controller -> datapath
  typedef struct packed {
    logic push;       // accept a push beat
    logic pop_empty;  // accept a pop on an empty queue
    logic pop_start;  // accept a pop, advance head, read slot length
    logic len_load;   // capture slot length, clear read index
    logic rd_issue;   // issue one frame byte read
  } ffd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;       // no committed frame held
    logic load_ok;     // output register can take a result this cycle
    logic can_issue;   // read stage free (or draining) this cycle
    logic stage_busy;  // read data waits in the read stage
    logic rd_done;     // all bytes of the frame have been read
  } ffd_stat_t;

endpackage

// ===== rtl/ffd_in_if.sv =====
// Input channel: valid/ready handshake carrying one push or pop item.
interface ffd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [ffd_pkg::BYTE_W-1:0] push_byte;
  logic                      push_last;

  modport source (output valid, action, push_byte, push_last, input ready);
  modport sink   (input valid, action, push_byte, push_last, output ready);
endinterface

// ===== rtl/ffd_out_if.sv =====
// Result channel: valid/ready handshake carrying one result beat.
interface ffd_out_if;
  logic                       valid;
  logic                       ready;
  logic [ffd_pkg::STAT_W-1:0] status;
  logic [ffd_pkg::BYTE_W-1:0] out_byte;
  logic                       out_last;
  logic [ffd_pkg::LEN_W-1:0]  frame_length;
  logic                       queue_empty;
  logic [ffd_pkg::DROP_W-1:0] drop_count;

  modport source (output valid, status, out_byte, out_last, frame_length, queue_empty,
                  drop_count, input ready);
  modport sink   (input valid, status, out_byte, out_last, frame_length, queue_empty,
                  drop_count, output ready);
endinterface

// ===== rtl/ffd_ram.sv =====
// Generic simple dual-port RAM with registered read; read data holds when idle.
module ffd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/ffd_ctrl.sv =====
// Controller FSM: item acceptance and sequencing of pop reads.
module ffd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  input  ffd_pkg::ffd_stat_t st,
  output ffd_pkg::ffd_cmd_t  cmd
);

  ffd_pkg::ffd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ffd_pkg::S_IDLE: begin
        in_ready = st.load_ok && !st.stage_busy;
        if (in_valid && in_ready) begin
          priority if (in_action == ffd_pkg::ACT_PUSH) begin
            cmd.push = 1'b1;
          end else if (st.empty) begin
            cmd.pop_empty = 1'b1;
          end else begin
            cmd.pop_start = 1'b1;
            state_nxt     = ffd_pkg::S_LEN_RD;
          end
        end
      end
      ffd_pkg::S_LEN_RD: begin
        cmd.len_load = 1'b1;
        state_nxt    = ffd_pkg::S_STREAM;
      end
      ffd_pkg::S_STREAM: begin
        if (!st.rd_done) begin
          cmd.rd_issue = st.can_issue;
        end else if (!st.stage_busy) begin
          state_nxt = ffd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ffd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ffd_dp.sv =====
// Datapath: ring pointers, counters, frame and length stores, read stage, output register.
module ffd_dp #(
  parameter int QUEUE_DEPTH = 8,
  parameter int FRAME_BYTES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ffd_pkg::BYTE_W-1:0]  push_byte,
  input  logic                        push_last,
  input  ffd_pkg::ffd_cmd_t           cmd,
  output ffd_pkg::ffd_stat_t          st,
  ffd_out_if.source                   out_ch
);

  localparam int SW     = $clog2(QUEUE_DEPTH);
  localparam int CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int OW     = $clog2(FRAME_BYTES + 1);
  localparam int AOW    = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int FDEPTH = QUEUE_DEPTH * (2 ** AOW);

  logic [SW-1:0]             head_r, head_nxt, tail_r, tail_nxt, rd_slot_r;
  logic [CW-1:0]             held_r, held_nxt;
  logic [ffd_pkg::DROP_W-1:0] drop_r, drop_nxt;
  logic [OW-1:0]             wo_r, wo_nxt, off_inc;
  logic [1:0]                refused_r, refused_nxt;
  logic [OW-1:0]             len_r, rd_idx_r;
  logic                      pend_r, pend_last_r;

  logic                      full, ref_full, long_now, ref_long, move, load;
  logic                      fr_we, len_we;
  logic [ffd_pkg::BYTE_W-1:0] fr_rd_data;
  logic [ffd_pkg::LEN_W-1:0]  len_rd_data;

  logic [ffd_pkg::STAT_W-1:0] res_status;
  logic [ffd_pkg::BYTE_W-1:0] res_byte;
  logic                       res_last;
  logic [ffd_pkg::LEN_W-1:0]  res_len;

  logic                       ov_r;
  logic [ffd_pkg::STAT_W-1:0] o_status_r;
  logic [ffd_pkg::BYTE_W-1:0] o_byte_r;
  logic                       o_last_r;
  logic [ffd_pkg::LEN_W-1:0]  o_len_r;
  logic                       o_empty_r;
  logic [ffd_pkg::DROP_W-1:0] o_drop_r;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  // push-side refusal tracking
  assign full     = (held_r == CW'(QUEUE_DEPTH));
  assign ref_full = refused_r[0] | ((wo_r == '0) && full);
  assign long_now = (wo_r == OW'(FRAME_BYTES));
  assign ref_long = refused_r[1] | long_now;
  assign off_inc  = long_now ? wo_r : wo_r + 1'b1;
  assign fr_we    = cmd.push && !long_now && !ref_full;
  assign len_we   = cmd.push && push_last && !ref_long && !ref_full;

  assign st.load_ok    = !ov_r || out_ch.ready;
  assign move          = pend_r && st.load_ok;
  assign st.can_issue  = !pend_r || move;
  assign st.stage_busy = pend_r;
  assign st.rd_done    = (rd_idx_r == len_r);
  assign st.empty      = (held_r == '0);

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    held_nxt    = held_r;
    drop_nxt    = drop_r;
    wo_nxt      = wo_r;
    refused_nxt = refused_r;
    load        = 1'b0;
    res_status  = ffd_pkg::ST_POPPED;
    res_byte    = '0;
    res_last    = 1'b1;
    res_len     = '0;
    if (cmd.push) begin
      if (!push_last) begin
        wo_nxt      = off_inc;
        refused_nxt = {ref_long, ref_full};
      end else begin
        wo_nxt      = '0;
        refused_nxt = '0;
        load        = 1'b1;
        priority if (ref_long) begin
          res_status = ffd_pkg::ST_TOO_LONG;
        end else if (ref_full) begin
          res_status = ffd_pkg::ST_DROPPED;
          drop_nxt   = drop_r + 1'b1;
        end else begin
          res_status = ffd_pkg::ST_STORED;
          res_len    = ffd_pkg::LEN_W'(off_inc);
          tail_nxt   = slot_inc(tail_r);
          held_nxt   = held_r + 1'b1;
        end
      end
    end else if (cmd.pop_empty) begin
      load       = 1'b1;
      res_status = ffd_pkg::ST_EMPTY;
    end else if (cmd.pop_start) begin
      head_nxt = slot_inc(head_r);
      held_nxt = held_r - 1'b1;
    end else if (move) begin
      load     = 1'b1;
      res_byte = fr_rd_data;
      res_last = pend_last_r;
      res_len  = ffd_pkg::LEN_W'(len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      held_r    <= '0;
      drop_r    <= '0;
      wo_r      <= '0;
      refused_r <= '0;
      pend_r    <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      held_r    <= held_nxt;
      drop_r    <= drop_nxt;
      wo_r      <= wo_nxt;
      refused_r <= refused_nxt;
      if (cmd.rd_issue) begin
        pend_r <= 1'b1;
      end else if (move) begin
        pend_r <= 1'b0;
      end
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // pop bookkeeping and result payload, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.pop_start) begin
      rd_slot_r <= head_r;
    end
    if (cmd.len_load) begin
      len_r    <= len_rd_data[OW-1:0];
      rd_idx_r <= '0;
    end else if (cmd.rd_issue) begin
      rd_idx_r    <= rd_idx_r + 1'b1;
      pend_last_r <= ((rd_idx_r + 1'b1) == len_r);
    end
    if (load) begin
      o_status_r <= res_status;
      o_byte_r   <= res_byte;
      o_last_r   <= res_last;
      o_len_r    <= res_len;
      o_empty_r  <= (held_nxt == '0);
      o_drop_r   <= drop_nxt;
    end
  end

  ffd_ram #(.WIDTH(ffd_pkg::BYTE_W), .DEPTH(FDEPTH)) u_frame_ram (
    .clk     (clk),
    .wr_en   (fr_we),
    .wr_addr ({tail_r, wo_r[AOW-1:0]}),
    .wr_data (push_byte),
    .rd_en   (cmd.rd_issue),
    .rd_addr ({rd_slot_r, rd_idx_r[AOW-1:0]}),
    .rd_data (fr_rd_data)
  );

  ffd_ram #(.WIDTH(ffd_pkg::LEN_W), .DEPTH(QUEUE_DEPTH)) u_len_ram (
    .clk     (clk),
    .wr_en   (len_we),
    .wr_addr (tail_r),
    .wr_data (ffd_pkg::LEN_W'(off_inc)),
    .rd_en   (cmd.pop_start),
    .rd_addr (head_r),
    .rd_data (len_rd_data)
  );

  assign out_ch.valid        = ov_r;
  assign out_ch.status       = o_status_r;
  assign out_ch.out_byte     = o_byte_r;
  assign out_ch.out_last     = o_last_r;
  assign out_ch.frame_length = o_len_r;
  assign out_ch.queue_empty  = o_empty_r;
  assign out_ch.drop_count   = o_drop_r;

endmodule

// ===== rtl/frame_fifo_with_drop.sv =====
// A last push beat and an empty pop each give their result through the output register.
// A pop of an L-byte frame reads the slot length, then byte reads run through the frame
// store's registered port and the output register, one byte per cycle while not stalled.
// Push beats are taken one per cycle unless the output stalls; a pop holds the input
// until its last byte reaches the output register. Reset (synchronous, rst_n low) clears
// pointers, counters and handshake state; the frame and length stores are not cleared.
module frame_fifo_with_drop #(
  parameter int QUEUE_DEPTH = 8,
  parameter int FRAME_BYTES = 64
) (
  input logic        clk,
  input logic        rst_n,
  ffd_in_if.sink     in_ch,
  ffd_out_if.source  out_ch
);

  ffd_pkg::ffd_cmd_t  cmd;
  ffd_pkg::ffd_stat_t st;
  logic               ready;

  // Controller owns the input handshake and sequences each pop:
  // accept -> read slot length -> stream byte reads.
  ffd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (ready),
    .st        (st),
    .cmd       (cmd)
  );

  assign in_ch.ready = ready;

  // Datapath holds ring state, the two stores and the result register.
  // The store's read register acts as a second stage, so a stalled
  // output still lets one byte wait without losing it.
  ffd_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_byte (in_ch.push_byte),
    .push_last (in_ch.push_last),
    .cmd       (cmd),
    .st        (st),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/ffd_checker.sv =====
// Port-level checker for the frame FIFO result channel, bound to the top level.
module ffd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ffd_pkg::STAT_W-1:0] status,
  input logic [ffd_pkg::BYTE_W-1:0] out_byte,
  input logic                       out_last,
  input logic [ffd_pkg::LEN_W-1:0]  frame_length,
  input logic                       queue_empty
);

  // a stalled beat keeps its content
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_byte)
      && $stable(out_last) && $stable(frame_length))
    else $error("result beat changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ffd_pkg::ST_EMPTY) |-> queue_empty && out_last
      && (frame_length == '0) && (out_byte == '0))
    else $error("empty-queue beat malformed");

  a_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ffd_pkg::ST_STORED) |-> !queue_empty && out_last
      && (frame_length != '0))
    else $error("stored-frame beat malformed");

  a_popped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ffd_pkg::ST_POPPED) |-> (frame_length != '0))
    else $error("popped byte without frame length");

  a_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ffd_pkg::ST_POPPED) |-> (out_byte == '0) && out_last)
    else $error("non-pop beat carries a byte or is not last");

endmodule

bind frame_fifo_with_drop ffd_checker u_ffd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .out_byte     (out_ch.out_byte),
  .out_last     (out_ch.out_last),
  .frame_length (out_ch.frame_length),
  .queue_empty  (out_ch.queue_empty)
);

// ===== test/tb_top.sv =====
// Self-checking bench for the frame FIFO with drop-on-full: random stalls, inline prediction.
module tb_top;

  localparam int QD = 8;            // slots in the ring
  localparam int FB = 64;           // bytes per slot
  localparam int STALL_LIMIT = 4000; // cycles with no beat on either side
  localparam int TAIL_CYCLES = 12;  // settle time after the last result
  localparam int SHOWN_MAX = 10;    // mismatches printed in full

  // refusal flags of the frame under assembly
  localparam logic [1:0] REFUSE_FULL = 2'b01;
  localparam logic [1:0] REFUSE_LONG = 2'b10;

  typedef struct {
    logic                       action;
    logic [ffd_pkg::BYTE_W-1:0] data;
    logic                       last;
  } cmd_beat_t;

  typedef struct {
    ffd_pkg::ffd_status_t       status;
    logic [ffd_pkg::BYTE_W-1:0] data;
    logic                       last;
    logic [ffd_pkg::LEN_W-1:0]  len;
    logic                       empty;
    logic [ffd_pkg::DROP_W-1:0] drops;
  } result_beat_t;

  logic clk;
  logic rst_n;

  ffd_in_if  in_ch ();
  ffd_out_if out_ch ();

  frame_fifo_with_drop #(
    .QUEUE_DEPTH(QD),
    .FRAME_BYTES(FB)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // ---------------------------------------------------------------------------
  // Clock: period 2
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the frame queue
  // ---------------------------------------------------------------------------
  logic [ffd_pkg::BYTE_W-1:0] sh_bytes [QD*FB];
  logic [ffd_pkg::LEN_W-1:0]  sh_len   [QD];
  int unsigned                sh_head;
  int unsigned                sh_tail;
  int unsigned                sh_held;
  logic [ffd_pkg::DROP_W-1:0] sh_drops;
  int unsigned                sh_fill;   // bytes seen of the frame in progress, stops at FB
  logic [1:0]                 sh_refuse;

  cmd_beat_t    cmds_to_send [$];  // stimulus not yet offered
  result_beat_t owed_results [$];  // results the DUT still has to produce

  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned queued_total;
  int unsigned fail_count;
  int unsigned quiet_cycles;

  // Apply one accepted beat to the shadow queue and append the results it causes.
  task automatic step_frame_queue(input cmd_beat_t c);
    result_beat_t r;
    int unsigned  slot;
    int unsigned  n;
    if (c.action == ffd_pkg::ACT_PUSH) begin
      // full check happens only on the first byte of a frame
      if (sh_fill == 0 && sh_held >= QD) sh_refuse |= REFUSE_FULL;
      if (sh_fill >= FB) begin
        sh_refuse |= REFUSE_LONG;
      end else begin
        if ((sh_refuse & REFUSE_FULL) == 2'b00) sh_bytes[sh_tail*FB + sh_fill] = c.data;
        sh_fill++;
      end
      if (c.last) begin
        r.data = '0;
        r.last = 1'b1;
        r.len  = '0;
        // too long takes priority over dropped-full
        if ((sh_refuse & REFUSE_LONG) != 2'b00) begin
          r.status = ffd_pkg::ST_TOO_LONG;
        end else if ((sh_refuse & REFUSE_FULL) != 2'b00) begin
          r.status = ffd_pkg::ST_DROPPED;
          sh_drops = sh_drops + 1'b1;
        end else begin
          r.status = ffd_pkg::ST_STORED;
          r.len = ffd_pkg::LEN_W'(sh_fill);
          sh_len[sh_tail] = ffd_pkg::LEN_W'(sh_fill);
          sh_tail = (sh_tail + 1) % QD;
          sh_held++;
        end
        sh_fill   = 0;
        sh_refuse = 2'b00;
        r.empty = (sh_held == 0);
        r.drops = sh_drops;
        owed_results.push_back(r);
      end
    end else if (sh_held == 0) begin
      r.status = ffd_pkg::ST_EMPTY;
      r.data   = '0;
      r.last   = 1'b1;
      r.len    = '0;
      r.empty  = 1'b1;
      r.drops  = sh_drops;
      owed_results.push_back(r);
    end else begin
      // stored frames are never empty, so n >= 1 here
      slot = sh_head;
      n = sh_len[slot];
      sh_head = (sh_head + 1) % QD;
      sh_held--;
      for (int unsigned i = 0; i < n; i++) begin
        r.status = ffd_pkg::ST_POPPED;
        r.data   = sh_bytes[slot*FB + i];
        r.last   = (i + 1 == n);
        r.len    = ffd_pkg::LEN_W'(n);
        r.empty  = (sh_held == 0);
        r.drops  = sh_drops;
        owed_results.push_back(r);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic add_push(input logic [ffd_pkg::BYTE_W-1:0] b, input logic lst);
    cmd_beat_t c;
    c.action = ffd_pkg::ACT_PUSH;
    c.data   = b;
    c.last   = lst;
    cmds_to_send.push_back(c);
    queued_total++;
  endtask

  // byte and last are don't-care on a pop; randomize them anyway
  task automatic add_pop();
    cmd_beat_t c;
    c.action = ffd_pkg::ACT_POP;
    c.data   = ffd_pkg::BYTE_W'($urandom);
    c.last   = 1'($urandom);
    cmds_to_send.push_back(c);
    queued_total++;
  endtask

  // n random bytes, last on the final one; pops may slip in between bytes
  task automatic add_frame(input int unsigned n, input int unsigned pop_pct);
    for (int unsigned i = 0; i < n; i++) begin
      if (i != 0 && $urandom_range(0, 99) < pop_pct) add_pop();
      add_push(ffd_pkg::BYTE_W'($urandom), i + 1 == n);
    end
  endtask

  // Random mix: short frames with pops between.
  task automatic add_random_mix(input int unsigned count, input int unsigned frame_pct);
    int unsigned stop_at;
    int unsigned n;
    stop_at = queued_total + count;
    while (queued_total < stop_at) begin
      if ($urandom_range(0, 99) < frame_pct) begin
        n = $urandom_range(1, 6);
        add_frame(n, 8);
      end else begin
        add_pop();
      end
    end
  endtask

  // Sender holds off until everything sent has come back.
  task automatic wait_drained();
    while (cmds_to_send.size() != 0 || in_ch.valid || owed_results.size() != 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the next queued beat, holds it until ready, predicts on accept
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_cmds
    cmd_beat_t c;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        c.action = in_ch.action;
        c.data   = in_ch.push_byte;
        c.last   = in_ch.push_last;
        step_frame_queue(c);
      end
      // a new beat only when the line is free; valid gets one assignment per edge
      if (!in_ch.valid || in_ch.ready) begin
        if (cmds_to_send.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          c = cmds_to_send.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.action    <= c.action;
          in_ch.push_byte <= c.data;
          in_ch.push_last <= c.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, compares each result beat with the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_beat_t w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_results.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOWN_MAX)
            $display("unexpected beat: st=%0d byte=%02h last=%0b len=%0d empty=%0b drops=%0d",
                     out_ch.status, out_ch.out_byte, out_ch.out_last, out_ch.frame_length,
                     out_ch.queue_empty, out_ch.drop_count);
        end else begin
          w = owed_results.pop_front();
          if (out_ch.status !== w.status || out_ch.out_byte !== w.data ||
              out_ch.out_last !== w.last || out_ch.frame_length !== w.len ||
              out_ch.queue_empty !== w.empty || out_ch.drop_count !== w.drops) begin
            fail_count++;
            if (fail_count <= SHOWN_MAX) begin
              $display("mismatch exp: st=%0d byte=%02h last=%0b len=%0d empty=%0b drops=%0d",
                       w.status, w.data, w.last, w.len, w.empty, w.drops);
              $display("         got: st=%0d byte=%02h last=%0b len=%0d empty=%0b drops=%0d",
                       out_ch.status, out_ch.out_byte, out_ch.out_last, out_ch.frame_length,
                       out_ch.queue_empty, out_ch.drop_count);
            end
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without a beat on either channel means a hang
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    // known levels from time zero
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ffd_pkg::ACT_PUSH;
    in_ch.push_byte = '0;
    in_ch.push_last = 1'b0;
    out_ch.ready    = 1'b0;
    quiet_cycles    = 0;
    fail_count      = 0;
    queued_total    = 0;
    sh_head   = 0;
    sh_tail   = 0;
    sh_held   = 0;
    sh_drops  = '0;
    sh_fill   = 0;
    sh_refuse = 2'b00;

    // phase 1: sender rarely idles, receiver mostly stalls
    snd_idle_pct = 7;
    rcv_idle_pct = 76;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    add_pop();                      // empty queue
    add_push(8'h00, 1'b1);          // one-byte frames at both byte extremes
    add_push(8'hFF, 1'b1);
    add_pop();
    add_pop();
    add_frame(FB, 0);               // exactly slot size
    add_pop();
    for (int i = 0; i < QD; i++) add_push(8'(i), 1'b1);  // fill every slot
    // first byte finds the queue full; a pop in between does not rescue it
    add_push(8'hA5, 1'b0);
    add_pop();
    add_push(8'h5A, 1'b1);
    add_push(8'h3C, 1'b1);          // refill the freed slot
    add_frame(FB + 1, 0);           // one over while full: too long wins, no count
    // pop served from the head while a frame is half built
    add_pop();
    add_push(8'h11, 1'b0);
    add_pop();
    add_push(8'h22, 1'b1);
    for (int i = 0; i < QD; i++) add_pop();   // drain, ending on an empty pop
    wait_drained();

    // phase 2: sender mostly idles, receiver rarely stalls
    snd_idle_pct = 76;
    rcv_idle_pct = 7;
    add_random_mix(8, 50);
    wait_drained();

    // phase 3: back to back on both sides
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    add_random_mix(8, 65);
    wait_drained();

    // catch any stray beat after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
